### rtl/i2cbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

    // command codes
    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_STOP     = 3'd1;
    localparam logic [2:0] CMD_SEND     = 3'd2;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    // slave that never pulls SDA low
    localparam logic [7:0] ACK_POLLS_NEVER   = 8'hFF;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    // longest command is a read with ack: 20 line states
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_MAX = 5'd19;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic last;
    } line_t;

endpackage

`default_nettype wire

### rtl/i2c_master_bit_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// I2C master bit sequencer: each command transfer yields a run of SCL/SDA line
// states, one per output transfer, the final one flagged by last_of_run. Run
// lengths in line states: start and stop 3, send byte 16, wait-ack 3
// (acknowledged) or 6 (timed out, with a stop), read byte 20 with ack or 19
// with nack. A step counter walks the held command one line state per cycle
// while the output register can take it; the next command is taken in the
// cycle its predecessor's last line state enters the output register, so with
// the output side always ready runs follow each other with no gap. Codes 5 to 7
// are taken and produce nothing. ack_timeout_polls resets to 250.
module i2c_master_bit_sequencer_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] command,
    input  wire logic [7:0] tx_byte,
    input  wire logic       send_ack,
    input  wire logic [7:0] rx_line_bits,
    input  wire logic [7:0] ack_high_polls,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_level,
    output logic            sda_level,
    output logic            last_of_run,
    output logic [7:0]      rx_byte,
    output logic            ack_failed
);

    logic [7:0]        ack_timeout_polls_reg;

    logic              busy_reg;
    logic [2:0]        cmd_reg;
    logic [7:0]        tx_reg;
    logic              ack_reg;
    logic [7:0]        rx_reg;
    logic              failed_reg;
    i2cbs_pkg::step_t  step_reg;

    logic              scl_state_reg;
    logic              sda_state_reg;

    logic              out_valid_reg;
    logic              scl_reg;
    logic              sda_reg;
    logic              last_reg;
    logic [7:0]        rx_byte_reg;
    logic              ack_failed_reg;

    logic              advance;
    logic              accept;
    logic              known_cmd;
    logic              failed_next;
    i2cbs_pkg::line_t  line;

    assign cfg_ready = 1'b1;

    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !busy_reg || (advance && line.last);
    assign accept    = in_valid && in_ready;
    assign known_cmd = (command inside {i2cbs_pkg::CMD_START, i2cbs_pkg::CMD_STOP,
                                        i2cbs_pkg::CMD_SEND, i2cbs_pkg::CMD_WAIT_ACK,
                                        i2cbs_pkg::CMD_READ});
    assign failed_next = (ack_high_polls == i2cbs_pkg::ACK_POLLS_NEVER)
                      || (ack_high_polls > ack_timeout_polls_reg);

    i2cbs_step u_step
    (
        .cmd       (cmd_reg),
        .tx_byte   (tx_reg),
        .send_ack  (ack_reg),
        .failed    (failed_reg),
        .step      (step_reg),
        .scl_state (scl_state_reg),
        .sda_state (sda_state_reg),
        .line      (line)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_polls_reg <= i2cbs_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ack_timeout_polls_reg <= cfg_data;
        end
    end

    // command register and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg <= known_cmd;
            step_reg <= '0;
        end
        else if (advance)
        begin
            busy_reg <= !line.last;
            step_reg <= step_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            tx_reg     <= tx_byte;
            ack_reg    <= send_ack;
            rx_reg     <= rx_line_bits;
            failed_reg <= failed_next;
        end
    end

    // lines as last driven
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_state_reg <= 1'b1;
            sda_state_reg <= 1'b1;
        end
        else if (advance)
        begin
            if (line.last && (cmd_reg == i2cbs_pkg::CMD_SEND))
            begin
                // hold SCL low and release SDA for the acknowledge
                scl_state_reg <= 1'b0;
                sda_state_reg <= 1'b1;
            end
            else
            begin
                scl_state_reg <= line.scl;
                sda_state_reg <= line.sda;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            scl_reg        <= line.scl;
            sda_reg        <= line.sda;
            last_reg       <= line.last;
            rx_byte_reg    <= (line.last && (cmd_reg == i2cbs_pkg::CMD_READ)) ? rx_reg : 8'd0;
            ack_failed_reg <= line.last && (cmd_reg == i2cbs_pkg::CMD_WAIT_ACK) && failed_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_level   = scl_reg;
    assign sda_level   = sda_reg;
    assign last_of_run = last_reg;
    assign rx_byte     = rx_byte_reg;
    assign ack_failed  = ack_failed_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= i2cbs_pkg::STEP_MAX))
        else $error("step counter beyond longest run");

    a_send_leaves_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && line.last && (cmd_reg == i2cbs_pkg::CMD_SEND))
        |=> (!scl_state_reg && sda_state_reg))
        else $error("send did not leave SCL low and SDA released");

    a_fail_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ack_failed_reg) |-> last_reg)
        else $error("ack failure flagged before end of run");

    a_rx_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (rx_byte_reg != 8'd0)) |-> last_reg)
        else $error("read byte shown before end of run");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !(advance && line.last)) |-> !in_ready)
        else $error("command taken while a run is in progress");

endmodule

`default_nettype wire

### rtl/i2cbs_step.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_step
(
    input  wire logic [2:0]     cmd,
    input  wire logic [7:0]     tx_byte,
    input  wire logic           send_ack,
    input  wire logic           failed,
    input  wire i2cbs_pkg::step_t step,
    input  wire logic           scl_state,
    input  wire logic           sda_state,
    output i2cbs_pkg::line_t    line
);

    logic       tx_bit;
    logic [2:0] bit_idx;

    assign bit_idx = 3'd7 - step[3:1];
    assign tx_bit  = tx_byte[bit_idx];

    always_comb
    begin
        line = '{scl: 1'b1, sda: 1'b1, last: 1'b1};
        case (cmd)
            i2cbs_pkg::CMD_START:
            begin
                line.scl  = (step != 5'd2);
                line.sda  = (step == 5'd0);
                line.last = (step == 5'd2);
            end
            i2cbs_pkg::CMD_STOP:
            begin
                line.scl  = (step == 5'd0) ? scl_state : 1'b1;
                line.sda  = (step == 5'd2);
                line.last = (step == 5'd2);
            end
            i2cbs_pkg::CMD_SEND:
            begin
                // low phase then high phase per bit, MSB first
                line.sda  = tx_bit;
                line.scl  = step[0] ? 1'b1 : ((step == 5'd0) ? scl_state : 1'b0);
                line.last = (step == 5'd15);
            end
            i2cbs_pkg::CMD_WAIT_ACK:
            begin
                if (failed)
                begin
                    // clock pulse, then a stop, then drop SCL with SDA released
                    case (step)
                        5'd0:    line = '{scl: scl_state, sda: 1'b1, last: 1'b0};
                        5'd1:    line = '{scl: 1'b1, sda: 1'b1, last: 1'b0};
                        5'd2:    line = '{scl: 1'b1, sda: 1'b0, last: 1'b0};
                        5'd3:    line = '{scl: 1'b1, sda: 1'b0, last: 1'b0};
                        5'd4:    line = '{scl: 1'b1, sda: 1'b1, last: 1'b0};
                        default: line = '{scl: 1'b0, sda: 1'b1, last: 1'b1};
                    endcase
                end
                else
                begin
                    case (step)
                        5'd0:    line = '{scl: scl_state, sda: 1'b1, last: 1'b0};
                        5'd1:    line = '{scl: 1'b1, sda: 1'b1, last: 1'b0};
                        default: line = '{scl: 1'b0, sda: 1'b1, last: 1'b1};
                    endcase
                end
            end
            i2cbs_pkg::CMD_READ:
            begin
                if (step < 5'd16)
                begin
                    // SDA held as last driven while the slave shifts out
                    line = '{scl: ~step[0], sda: sda_state, last: 1'b0};
                end
                else if (send_ack)
                begin
                    case (step)
                        5'd16:   line = '{scl: 1'b0, sda: 1'b0, last: 1'b0};
                        5'd17:   line = '{scl: 1'b1, sda: 1'b0, last: 1'b0};
                        5'd18:   line = '{scl: 1'b0, sda: 1'b0, last: 1'b0};
                        default: line = '{scl: 1'b0, sda: 1'b1, last: 1'b1};
                    endcase
                end
                else
                begin
                    case (step)
                        5'd16:   line = '{scl: 1'b0, sda: 1'b1, last: 1'b0};
                        5'd17:   line = '{scl: 1'b1, sda: 1'b1, last: 1'b0};
                        default: line = '{scl: 1'b0, sda: 1'b1, last: 1'b1};
                    endcase
                end
            end
            default:
            begin
                line = '{scl: scl_state, sda: sda_state, last: 1'b1};
            end
        endcase
    end

endmodule

`default_nettype wire

### verif/i2c_master_bit_sequencer_top_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_top_tb;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 30;
    localparam int SINK_STALL   = 400;
    localparam int IDLE_PCT     = 7;
    localparam int PHASE_ITEMS  = 35;

    // codes the block ignores
    localparam logic [2:0] CMD_RSVD_A = 3'd5;
    localparam logic [2:0] CMD_RSVD_B = 3'd6;
    localparam logic [2:0] CMD_RSVD_C = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic [7:0] rx_line_bits;
        logic [7:0] ack_high_polls;
    } bus_cmd_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       last;
        logic [7:0] rx;
        logic       fail;
    } line_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] command = i2cbs_pkg::CMD_START;
    logic [7:0] tx_byte = 8'd0;
    logic       send_ack = 1'b0;
    logic [7:0] rx_line_bits = 8'd0;
    logic [7:0] ack_high_polls = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       last_of_run;
    logic [7:0] rx_byte;
    logic       ack_failed;

    i2c_master_bit_sequencer_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .tx_byte        (tx_byte),
        .send_ack       (send_ack),
        .rx_line_bits   (rx_line_bits),
        .ack_high_polls (ack_high_polls),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scl_level      (scl_level),
        .sda_level      (sda_level),
        .last_of_run    (last_of_run),
        .rx_byte        (rx_byte),
        .ack_failed     (ack_failed)
    );

    always #5 clk = ~clk;

    bus_cmd_t    pending_cmds[$];
    line_state_t expected_states[$];

    // mirror of the block: timeout register and lines as last driven
    logic [7:0] ack_timeout = i2cbs_pkg::ACK_TIMEOUT_RESET;
    logic       scl_now = 1'b1;
    logic       sda_now = 1'b1;

    int  errors = 0;
    int  cycles = 0;
    int  results_seen = 0;
    int  sink_hold = 0;
    bit  sink_stall_done = 1'b0;
    bit  calm = 1'b0;
    int  issued = 0;
    line_state_t want_state;
    line_state_t seen_state;

    task automatic push_state(input logic scl, input logic sda, input logic last,
                              input logic [7:0] rx, input logic fail);
        line_state_t s;
        scl_now = scl;
        sda_now = sda;
        s.scl = scl;
        s.sda = sda;
        s.last = last;
        s.rx = rx;
        s.fail = fail;
        expected_states.push_back(s);
    endtask

    task automatic predict_line_states(input bus_cmd_t c);
        logic failed;
        logic b;
        int   i;
        case (c.command)
            i2cbs_pkg::CMD_START:
            begin
                push_state(1'b1, 1'b1, 1'b0, 8'd0, 1'b0);
                push_state(1'b1, 1'b0, 1'b0, 8'd0, 1'b0);
                push_state(1'b0, 1'b0, 1'b1, 8'd0, 1'b0);
            end
            i2cbs_pkg::CMD_STOP:
            begin
                push_state(scl_now, 1'b0, 1'b0, 8'd0, 1'b0);
                push_state(1'b1, 1'b0, 1'b0, 8'd0, 1'b0);
                push_state(1'b1, 1'b1, 1'b1, 8'd0, 1'b0);
            end
            i2cbs_pkg::CMD_SEND:
            begin
                for (i = 7; i >= 0; i--)
                begin
                    b = c.tx_byte[i];
                    push_state(scl_now, b, 1'b0, 8'd0, 1'b0);
                    push_state(1'b1, b, i == 0, 8'd0, 1'b0);
                    scl_now = 1'b0;
                end
                // SDA is released afterwards with no interval of its own
                scl_now = 1'b0;
                sda_now = 1'b1;
            end
            i2cbs_pkg::CMD_WAIT_ACK:
            begin
                failed = (c.ack_high_polls == i2cbs_pkg::ACK_POLLS_NEVER) ||
                         (c.ack_high_polls > ack_timeout);
                push_state(scl_now, 1'b1, 1'b0, 8'd0, 1'b0);
                push_state(1'b1, 1'b1, 1'b0, 8'd0, 1'b0);
                if (failed)
                begin
                    push_state(1'b1, 1'b0, 1'b0, 8'd0, 1'b0);
                    push_state(1'b1, 1'b0, 1'b0, 8'd0, 1'b0);
                    push_state(1'b1, 1'b1, 1'b0, 8'd0, 1'b0);
                end
                push_state(1'b0, sda_now, 1'b1, 8'd0, failed);
            end
            i2cbs_pkg::CMD_READ:
            begin
                for (i = 0; i < 8; i++)
                begin
                    push_state(1'b1, sda_now, 1'b0, 8'd0, 1'b0);
                    push_state(1'b0, sda_now, 1'b0, 8'd0, 1'b0);
                end
                if (c.send_ack)
                begin
                    push_state(1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
                    push_state(1'b1, 1'b0, 1'b0, 8'd0, 1'b0);
                    push_state(1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
                    push_state(1'b0, 1'b1, 1'b1, c.rx_line_bits, 1'b0);
                end
                else
                begin
                    push_state(1'b0, 1'b1, 1'b0, 8'd0, 1'b0);
                    push_state(1'b1, 1'b1, 1'b0, 8'd0, 1'b0);
                    push_state(1'b0, 1'b1, 1'b1, c.rx_line_bits, 1'b0);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // command driver: hold the offered command until its transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_line_states(pending_cmds[0]);
                void'(pending_cmds.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid       <= 1'b1;
                    command        <= pending_cmds[0].command;
                    tx_byte        <= pending_cmds[0].tx_byte;
                    send_ack       <= pending_cmds[0].send_ack;
                    rx_line_bits   <= pending_cmds[0].rx_line_bits;
                    ack_high_polls <= pending_cmds[0].ack_high_polls;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // line state monitor and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen_state.scl  = scl_level;
                seen_state.sda  = sda_level;
                seen_state.last = last_of_run;
                seen_state.rx   = rx_byte;
                seen_state.fail = ack_failed;
                if (expected_states.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected line state scl=%b sda=%b last=%b rx=%h fail=%b",
                             $time, seen_state.scl, seen_state.sda, seen_state.last,
                             seen_state.rx, seen_state.fail);
                end
                else
                begin
                    want_state = expected_states.pop_front();
                    if (seen_state !== want_state)
                    begin
                        errors++;
                        $write("%0t: line state mismatch: expected scl=%b sda=%b last=%b ",
                               $time, want_state.scl, want_state.sda, want_state.last);
                        $write("rx=%h fail=%b, ", want_state.rx, want_state.fail);
                        $display("got scl=%b sda=%b last=%b rx=%h fail=%b",
                                 seen_state.scl, seen_state.sda, seen_state.last,
                                 seen_state.rx, seen_state.fail);
                    end
                end
                results_seen++;
                // hold off once the sender has plenty queued, so the block backs up
                if (!sink_stall_done && results_seen >= 300 && pending_cmds.size() > 10)
                begin
                    sink_stall_done = 1'b1;
                    sink_hold = SINK_STALL;
                end
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("i2c_master_bit_sequencer_top verification failed");
            $finish;
        end
    end

    task automatic add_cmd(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
                           input logic [7:0] rx, input logic [7:0] polls);
        bus_cmd_t c;
        c.command = cmd;
        c.tx_byte = tx;
        c.send_ack = ack;
        c.rx_line_bits = rx;
        c.ack_high_polls = polls;
        pending_cmds.push_back(c);
        if (cmd <= i2cbs_pkg::CMD_READ)
            issued++;
    endtask

    task automatic add_random(input logic [2:0] cmd);
        int t;
        logic [7:0] polls;
        case ($urandom_range(3))
            0: polls = i2cbs_pkg::ACK_POLLS_NEVER;
            1:
            begin
                // straddle the timeout boundary
                t = int'(ack_timeout);
                t = t + int'($urandom_range(2)) - 1;
                if (t < 0)
                    t = 0;
                if (t > 255)
                    t = 255;
                polls = t[7:0];
            end
            default: polls = 8'($urandom);
        endcase
        add_cmd(cmd, 8'($urandom), 1'($urandom), 8'($urandom), polls);
    endtask

    task automatic add_transaction();
        int n;
        int k;
        add_random(i2cbs_pkg::CMD_START);
        add_random(i2cbs_pkg::CMD_SEND);
        add_random(i2cbs_pkg::CMD_WAIT_ACK);
        n = int'($urandom_range(3, 1));
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(1) == 1)
            begin
                add_random(i2cbs_pkg::CMD_SEND);
                add_random(i2cbs_pkg::CMD_WAIT_ACK);
            end
            else
            begin
                add_random(i2cbs_pkg::CMD_READ);
            end
        end
        add_random(i2cbs_pkg::CMD_STOP);
    endtask

    task automatic add_random_phase(input int target);
        while (issued < target)
        begin
            // some noise and broken sequences among the well-formed ones
            if ($urandom_range(5) == 0)
                add_random(3'($urandom_range(7)));
            else
                add_transaction();
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_cmds.size() != 0 || expected_states.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ack_timeout = v;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // timeout register at its reset value
        add_cmd(i2cbs_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 8'h00);
        add_cmd(i2cbs_pkg::CMD_SEND, 8'h00, 1'b0, 8'h00, 8'h00);
        add_cmd(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, 8'd0);
        add_cmd(i2cbs_pkg::CMD_SEND, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        add_cmd(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, 8'd250);
        add_cmd(i2cbs_pkg::CMD_SEND, 8'hA5, 1'b0, 8'h00, 8'h00);
        add_cmd(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, 8'd251);
        add_cmd(i2cbs_pkg::CMD_READ, 8'h00, 1'b1, 8'h00, 8'h00);
        add_cmd(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, 8'hFF, 8'h00);
        add_cmd(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 8'h00);
        add_cmd(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 8'h00);
        add_cmd(CMD_RSVD_A, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        add_cmd(CMD_RSVD_B, 8'h00, 1'b0, 8'h00, 8'h00);
        add_cmd(CMD_RSVD_C, 8'h5A, 1'b1, 8'hA5, 8'd7);
        add_cmd(i2cbs_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 8'h00);
        // read straight after start samples with SDA low
        add_cmd(i2cbs_pkg::CMD_READ, 8'h00, 1'b1, 8'h5A, 8'h00);
        add_cmd(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, i2cbs_pkg::ACK_POLLS_NEVER);
        wait_drained();

        // silent slave must still time out with the register at its maximum
        write_timeout(8'hFF);
        add_cmd(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, 8'd254);
        add_cmd(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, i2cbs_pkg::ACK_POLLS_NEVER);
        add_cmd(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 8'h00);
        wait_drained();

        write_timeout(8'h00);
        add_cmd(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, 8'd0);
        add_cmd(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, 8'd1);
        wait_drained();

        write_timeout(8'($urandom));
        add_random_phase(issued + PHASE_ITEMS);
        wait_drained();

        write_timeout(8'($urandom_range(20, 1)));
        add_random_phase(issued + PHASE_ITEMS);
        wait_drained();

        // a stretch with no idling on either side
        calm = 1'b1;
        write_timeout(i2cbs_pkg::ACK_TIMEOUT_RESET);
        add_random_phase(issued + PHASE_ITEMS);
        wait_drained();
        calm = 1'b0;

        write_timeout(8'($urandom));
        add_random_phase(issued + PHASE_ITEMS);
        wait_drained();

        if (errors == 0 && expected_states.size() == 0)
            $display("i2c_master_bit_sequencer_top verification clean");
        else
            $display("i2c_master_bit_sequencer_top verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/i2cbs_pkg.sv
rtl/i2cbs_step.sv
rtl/i2c_master_bit_sequencer_top.sv
verif/i2c_master_bit_sequencer_top_tb.sv
